// ----- hdl/ilir_pkg.sv -----
package ilir_pkg;

	// List geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths
	localparam int CMD_W    = 2;
	localparam int POS_W    = 8;
	localparam int WORD_W   = 32;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 7;
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Stream word widths, padded to whole bytes
	localparam int S_FIELDS_W = CMD_W + POS_W + WORD_W;
	localparam int M_FIELDS_W = WORD_W + STAT_W + COUNT_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] word;
		status_t                  status;
		logic [COUNT_W-1:0]       count;
	} res_t;

endpackage

// ----- hdl/ilir_core.sv -----
module ilir_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cmd_valid,
	output logic                                    cmd_ready,
	input  ilir_pkg::cmd_t                          cmd_op,
	input  logic [ilir_pkg::POS_W-1:0]              cmd_pos,
	input  logic signed [ilir_pkg::WORD_W-1:0]      cmd_word,
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output ilir_pkg::res_t                          res
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_UP     = 6'b000010,
		ST_DN     = 6'b000100,
		ST_FILL   = 6'b001000,
		ST_RDWAIT = 6'b010000,
		ST_POST   = 6'b100000
	} state_t;

	state_t                                 state_q;
	state_t                                 dec_state;
	logic [ilir_pkg::CNT_W-1:0]             count_q;
	logic [ilir_pkg::IDX_W-1:0]             addr_q;
	logic [ilir_pkg::IDX_W-1:0]             last_q;
	logic [ilir_pkg::IDX_W-1:0]             pos_q;
	logic signed [ilir_pkg::WORD_W-1:0]     word_q;
	logic signed [ilir_pkg::WORD_W-1:0]     rdata_q;
	logic signed [ilir_pkg::WORD_W-1:0]     res_word_q;
	ilir_pkg::status_t                      res_status_q;
	ilir_pkg::status_t                      dec_status;
	logic                                   dec_inc;
	logic                                   dec_dec;
	logic                                   accept;
	logic                                   full;
	logic [ilir_pkg::CMP_W-1:0]             pos_ext;
	logic [ilir_pkg::CMP_W-1:0]             cnt_ext;
	logic [ilir_pkg::IDX_W-1:0]             pos_idx;
	logic [ilir_pkg::IDX_W-1:0]             cnt_idx;
	logic                                   mem_we;
	logic [ilir_pkg::IDX_W-1:0]             mem_waddr;
	logic signed [ilir_pkg::WORD_W-1:0]     mem_wdata;
	logic [ilir_pkg::IDX_W-1:0]             mem_raddr;
	logic signed [ilir_pkg::WORD_W-1:0]     mem [ilir_pkg::CAPACITY];

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign pos_ext   = ilir_pkg::CMP_W'(cmd_pos);
	assign cnt_ext   = ilir_pkg::CMP_W'(count_q);
	assign pos_idx   = cmd_pos[ilir_pkg::IDX_W-1:0];
	assign cnt_idx   = count_q[ilir_pkg::IDX_W-1:0];
	assign full      = (count_q >= ilir_pkg::CNT_W'(ilir_pkg::CAPACITY));

	// Decode the command and steer the memory ports
	always_comb begin
		dec_status = ilir_pkg::STAT_OK;
		dec_state  = ST_POST;
		dec_inc    = 1'b0;
		dec_dec    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = cnt_idx;
		mem_wdata  = cmd_word;
		mem_raddr  = addr_q;
		unique case (state_q)
			ST_IDLE: begin
				unique case (cmd_op)
					ilir_pkg::CMD_APPEND: begin
						if (full) begin
							dec_status = ilir_pkg::STAT_FULL;
						end else begin
							dec_inc = 1'b1;
							mem_we  = cmd_valid;
						end
					end
					ilir_pkg::CMD_INSERT: begin
						mem_raddr = cnt_idx - ilir_pkg::IDX_W'(1);
						if (pos_ext > cnt_ext) begin
							dec_status = ilir_pkg::STAT_RANGE;
						end else if (full) begin
							dec_status = ilir_pkg::STAT_FULL;
						end else if (pos_ext == cnt_ext) begin
							// insert at the end is an append
							dec_inc = 1'b1;
							mem_we  = cmd_valid;
						end else begin
							dec_inc   = 1'b1;
							dec_state = ST_UP;
						end
					end
					ilir_pkg::CMD_REMOVE: begin
						mem_raddr = pos_idx + ilir_pkg::IDX_W'(1);
						if (pos_ext >= cnt_ext) begin
							dec_status = ilir_pkg::STAT_RANGE;
						end else if (pos_ext + ilir_pkg::CMP_W'(1) == cnt_ext) begin
							// last entry: nothing to move down
							dec_dec = 1'b1;
						end else begin
							dec_dec   = 1'b1;
							dec_state = ST_DN;
						end
					end
					ilir_pkg::CMD_READ: begin
						mem_raddr = pos_idx;
						if (pos_ext >= cnt_ext) begin
							dec_status = ilir_pkg::STAT_RANGE;
						end else begin
							dec_state = ST_RDWAIT;
						end
					end
				endcase
			end
			ST_UP: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q + ilir_pkg::IDX_W'(1);
				mem_wdata = rdata_q;
				mem_raddr = addr_q - ilir_pkg::IDX_W'(1);
			end
			ST_DN: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q - ilir_pkg::IDX_W'(1);
				mem_wdata = rdata_q;
				mem_raddr = addr_q + ilir_pkg::IDX_W'(1);
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = word_q;
			end
			default: begin
			end
		endcase
	end

	// Entry store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Sequencer and list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= dec_state;
						if (dec_inc) begin
							count_q <= count_q + ilir_pkg::CNT_W'(1);
						end else if (dec_dec) begin
							count_q <= count_q - ilir_pkg::CNT_W'(1);
						end
					end
				end
				ST_UP: begin
					if (addr_q == pos_q) begin
						state_q <= ST_FILL;
					end
				end
				ST_DN: begin
					if (addr_q == last_q) begin
						state_q <= ST_POST;
					end
				end
				ST_FILL:   state_q <= ST_POST;
				ST_RDWAIT: state_q <= ST_POST;
				ST_POST: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the command operands and walk the shift pointer
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q        <= pos_idx;
			word_q       <= cmd_word;
			addr_q       <= mem_raddr;
			last_q       <= cnt_idx - ilir_pkg::IDX_W'(1);
			res_status_q <= dec_status;
			res_word_q   <= '0;
		end else if (state_q == ST_UP || state_q == ST_DN) begin
			addr_q <= mem_raddr;
		end else if (state_q == ST_RDWAIT) begin
			res_word_q <= rdata_q;
		end
	end

	assign res_valid  = (state_q == ST_POST);
	assign res.word   = res_word_q;
	assign res.status = res_status_q;
	assign res.count  = ilir_pkg::COUNT_W'(count_q);

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ilir_pkg::CNT_W'(ilir_pkg::CAPACITY))
		else $error("list length beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UP |-> addr_q >= pos_q)
		else $error("upward shift ran past the insert position");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DN |-> addr_q <= last_q)
		else $error("downward shift ran past the list end");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && dec_status != ilir_pkg::STAT_OK |=> $stable(count_q))
		else $error("rejected command changed the list length");

endmodule

// ----- hdl/indexed_list_insert_remove.sv -----
// Operation: append, rejected commands and remove of the last entry post their result directly
// after acceptance, read after the registered memory read; insert shifts the entries from the
// position to the end up by one slot and then writes the word, remove shifts the entries after
// the position down by one slot, one entry moved per cycle. Throughput: one command at a time;
// a result held in the output register stalls the next command at its end until drained.
// Reset: arst_n empties the list and clears the handshakes; entry contents are not cleared.
module indexed_list_insert_remove (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ilir_pkg::S_TDATA_W-1:0]     s_tdata,  // command, position, word_in, pad
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ilir_pkg::M_TDATA_W-1:0]     m_tdata   // read_word, status, count_after, pad
);

	ilir_pkg::cmd_t                         cmd_op;
	logic [ilir_pkg::POS_W-1:0]             cmd_pos;
	logic signed [ilir_pkg::WORD_W-1:0]     cmd_word;
	logic                                   res_valid;
	logic                                   res_ready;
	ilir_pkg::res_t                         res;
	ilir_pkg::res_t                         out_q;
	logic                                   m_tvalid_q;

	// Unpack the input word
	assign cmd_op   = ilir_pkg::cmd_t'(s_tdata[ilir_pkg::CMD_W-1:0]);
	assign cmd_pos  = s_tdata[ilir_pkg::CMD_W +: ilir_pkg::POS_W];
	assign cmd_word = s_tdata[ilir_pkg::CMD_W + ilir_pkg::POS_W +: ilir_pkg::WORD_W];

	ilir_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd_op    (cmd_op),
		.cmd_pos   (cmd_pos),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: take a new result when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	// Pack the output word
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(ilir_pkg::M_TDATA_W - ilir_pkg::M_FIELDS_W){1'b0}},
		out_q.count, out_q.status, out_q.word};

endmodule
